// File: rtl/jtok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtok_pkg
// Shared widths, codes and record types of the JSON tokenizer.
// ----------------------------------------------------------------------------
package jtok_pkg;

  // Field widths fixed by the record format
  localparam int unsigned TEXT_W   = 8;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned OFF_W    = 16;
  localparam int unsigned KIDS_W   = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned LIMIT_W  = 9;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd256;
  localparam logic [KIDS_W-1:0]  KIDS_MAX    = 8'd255;

  // Parameter defaults
  localparam int unsigned MAX_TOKENS_DEF = 256;
  localparam int unsigned MAX_TEXT_DEF   = 65535;

  typedef enum logic {
    REC_TOKEN  = 1'b0,
    REC_STATUS = 1'b1
  } rec_kind_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_OBJECT = 2'd0,
    KIND_ARRAY  = 2'd1,
    KIND_STRING = 2'd2,
    KIND_PRIM   = 2'd3
  } token_kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 3'd0,
    ST_NOMEM = 3'd1,
    ST_INVAL = 3'd2,
    ST_PART  = 3'd3,
    ST_LONG  = 3'd4
  } status_e;

  // One open container
  typedef struct packed {
    logic [INDEX_W-1:0] slot;
    logic               is_array;
    logic [OFF_W-1:0]   start;
    logic [KIDS_W-1:0]  kids;
  } frame_t;

  // One result record
  typedef struct packed {
    logic                record_kind;
    logic [INDEX_W-1:0]  token_index;
    logic [KIND_W-1:0]   token_kind;
    logic [OFF_W-1:0]    start_offset;
    logic [OFF_W-1:0]    end_offset;
    logic [KIDS_W-1:0]   child_count;
    logic [STATUS_W-1:0] status;
    logic [LIMIT_W-1:0]  tokens_made;
    logic                last_of_run;
  } rec_t;

endpackage

// File: rtl/jtok_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtok_in_if
// Text byte channel: valid/ready with one byte and an end-of-text flag.
// ----------------------------------------------------------------------------
interface jtok_in_if;
  import jtok_pkg::*;

  logic              valid;
  logic              ready;
  logic [TEXT_W-1:0] text_byte;
  logic              end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);

endinterface

// File: rtl/jtok_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtok_out_if
// Record channel: valid/ready with one token or status record.
// ----------------------------------------------------------------------------
interface jtok_out_if;
  import jtok_pkg::*;

  logic                valid;
  logic                ready;
  logic                record_kind;
  logic [INDEX_W-1:0]  token_index;
  logic [KIND_W-1:0]   token_kind;
  logic [OFF_W-1:0]    start_offset;
  logic [OFF_W-1:0]    end_offset;
  logic [KIDS_W-1:0]   child_count;
  logic [STATUS_W-1:0] status;
  logic [LIMIT_W-1:0]  tokens_made;
  logic                last_of_run;

  modport source (
    output valid, output record_kind, output token_index, output token_kind,
    output start_offset, output end_offset, output child_count, output status,
    output tokens_made, output last_of_run, input ready
  );
  modport sink (
    input valid, input record_kind, input token_index, input token_kind,
    input start_offset, input end_offset, input child_count, input status,
    input tokens_made, input last_of_run, output ready
  );

endinterface

// File: rtl/jtok_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtok_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module jtok_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // read returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/json_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_tokenizer
// Streaming JSON tokenizer: one text byte in, token and status records out.
// ----------------------------------------------------------------------------
//
//   Channel   Dir  Moves                          Handshake
//   byte_i    in   text_byte, end_of_text         valid/ready
//   rec_o     out  token or status record         valid/ready
//   cfg_*     in   token_limit                    write enable, no wait
//
// One byte is taken per cycle while byte_i is ready. The byte is classified
// and the container stack updated in the cycle it is accepted; its up to
// three records go to a four-entry record queue, which drains one record
// per cycle while rec_o is ready. Bytes keep flowing while the queue holds
// at most one record, so bytes giving one record each sustain one byte per
// clock unless rec_o stalls; a byte giving more records holds byte_i off
// until the queue is back to one. Reset clears all control state; the stack
// RAM needs no clearing pass as only entries below the stack depth are read.
//
module json_tokenizer #(
  parameter int unsigned MAX_TOKENS = jtok_pkg::MAX_TOKENS_DEF,
  parameter int unsigned MAX_TEXT   = jtok_pkg::MAX_TEXT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [jtok_pkg::LIMIT_W-1:0] cfg_data_i,
  jtok_in_if.sink                      byte_i,
  jtok_out_if.source                   rec_o
);
  import jtok_pkg::*;

  // Stack depth and token count hold 0..MAX_TOKENS
  localparam int unsigned DW  = $clog2(MAX_TOKENS + 1);
  // RAM address; entries 0..MAX_TOKENS-2 hold the frames under the top
  localparam int unsigned AW  = (MAX_TOKENS > 1) ? $clog2(MAX_TOKENS) : 1;
  localparam int unsigned PW  = $clog2(MAX_TEXT + 1);
  localparam int unsigned LW  = (DW > LIMIT_W) ? DW : LIMIT_W;
  localparam int unsigned FW  = $bits(frame_t);
  // Record queue
  localparam int unsigned QD  = 4;
  localparam int unsigned QAW = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);
  localparam int unsigned RUN = 3;   // most records one byte can give

  localparam logic [TEXT_W-1:0] CH_TAB    = 8'h09;
  localparam logic [TEXT_W-1:0] CH_LF     = 8'h0A;
  localparam logic [TEXT_W-1:0] CH_CR     = 8'h0D;
  localparam logic [TEXT_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [TEXT_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [TEXT_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [TEXT_W-1:0] CH_COLON  = 8'h3A;
  localparam logic [TEXT_W-1:0] CH_LBRACK = 8'h5B;
  localparam logic [TEXT_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [TEXT_W-1:0] CH_RBRACK = 8'h5D;
  localparam logic [TEXT_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [TEXT_W-1:0] CH_RBRACE = 8'h7D;

  typedef enum logic [1:0] {
    MODE_IDLE,   // between tokens
    MODE_STR,    // inside a string
    MODE_ESC,    // after a backslash in a string
    MODE_PRIM    // inside a primitive
  } mode_e;

  // --------------------------------------------------------------------------
  // State
  // --------------------------------------------------------------------------
  logic [LIMIT_W-1:0] limit_q;
  mode_e              mode_q, mode_d;
  logic [PW-1:0]      pos_q, pos_d;
  logic [PW-1:0]      pend_q, pend_d;
  logic [DW-1:0]      tok_q, tok_d;
  logic [DW-1:0]      depth_q, depth_d;
  status_e            err_q, err_d;
  frame_t             top_q, top_d;     // top of stack lives in flops

  // record queue
  rec_t               fifo_q [QD];
  logic [QAW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [QCW-1:0]     count_q;

  // stack RAM and same-address bypass
  logic               ram_we;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [FW-1:0]      ram_rdata;
  logic               byp_q;
  frame_t             byp_data_q;
  frame_t             below;            // frame just under the top
  frame_t             wr_frame;

  logic               accept, pop;
  rec_t               recs [RUN];
  logic [1:0]         n_recs;
  logic [DW-1:0]      depth_next;

  assign accept = byte_i.valid & byte_i.ready;
  assign pop    = rec_o.valid & rec_o.ready;

  // room for a full run of records
  assign byte_i.ready = (count_q <= QCW'(1));

  assign below = byp_q ? byp_data_q : frame_t'(ram_rdata);

  // Effective token limit
  logic [LW-1:0] lim;
  assign lim = (LW'(limit_q) < LW'(MAX_TOKENS)) ? LW'(limit_q) : LW'(MAX_TOKENS);

  function automatic rec_t mk_token(logic [DW-1:0] idx, token_kind_e kind,
                                    logic [PW-1:0] s, logic [PW-1:0] e,
                                    logic [KIDS_W-1:0] kids);
    rec_t r;
    r              = '0;
    r.record_kind  = REC_TOKEN;
    r.token_index  = INDEX_W'(idx);
    r.token_kind   = kind;
    r.start_offset = OFF_W'(s);
    r.end_offset   = OFF_W'(e);
    r.child_count  = kids;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Byte classification and stack update
  // --------------------------------------------------------------------------
  always_comb begin
    logic [TEXT_W-1:0] c;
    logic              eot;
    logic [PW-1:0]     pos_inc;
    logic              leaf_req;
    token_kind_e       leaf_kind;
    logic [PW-1:0]     leaf_s, leaf_e;
    logic              do_switch;
    logic              delim, prim_char;
    status_e           st;

    c         = byte_i.text_byte;
    eot       = byte_i.end_of_text;
    pos_inc   = PW'(pos_q + 1'b1);
    mode_d    = mode_q;
    pos_d     = pos_q;
    pend_d    = pend_q;
    tok_d     = tok_q;
    depth_d   = depth_q;
    err_d     = err_q;
    top_d     = top_q;
    wr_frame  = top_q;
    ram_we    = 1'b0;
    n_recs    = '0;
    for (int i = 0; i < RUN; i++) begin
      recs[i] = '0;
    end
    leaf_req  = 1'b0;
    leaf_kind = KIND_PRIM;
    leaf_s    = pend_q;
    leaf_e    = pos_q;
    do_switch = 1'b0;
    st        = ST_OK;

    // bytes that end a primitive
    delim = (c == CH_TAB) || (c == CH_CR) || (c == CH_LF) || (c == CH_SPACE) ||
            (c == CH_COMMA) || (c == CH_RBRACK) || (c == CH_RBRACE);
    // bytes that start a primitive
    prim_char = (c >= CH_SPACE) && !delim && (c != CH_COLON) && (c != CH_QUOTE) &&
                (c != CH_BSLASH) && (c != CH_LBRACK) && (c != CH_LBRACE);

    if (err_q == ST_OK) begin
      if (pos_q >= PW'(MAX_TEXT)) begin
        err_d = ST_LONG;
      end else begin
        pos_d = pos_inc;
        unique case (mode_q)
          MODE_ESC: begin
            mode_d = MODE_STR;
          end
          MODE_STR: begin
            if (c == CH_BSLASH) begin
              mode_d = MODE_ESC;
            end else if (c == CH_QUOTE) begin
              mode_d    = MODE_IDLE;
              leaf_req  = 1'b1;
              leaf_kind = KIND_STRING;
            end
          end
          MODE_PRIM: begin
            if (delim) begin
              // report the primitive, then treat the delimiter between tokens
              mode_d    = MODE_IDLE;
              leaf_req  = 1'b1;
              do_switch = 1'b1;
            end else if (c < CH_SPACE) begin
              err_d = ST_INVAL;
            end else if (eot) begin
              mode_d   = MODE_IDLE;
              leaf_req = 1'b1;
              leaf_e   = pos_inc;
            end
          end
          MODE_IDLE: begin
            if (prim_char && eot) begin
              // one-byte primitive closed by end of text
              leaf_req = 1'b1;
              leaf_s   = pos_q;
              leaf_e   = pos_inc;
            end else begin
              do_switch = 1'b1;
            end
          end
        endcase

        // leaf token: string or primitive
        if (leaf_req) begin
          if (LW'(tok_d) >= lim) begin
            err_d     = ST_NOMEM;
            do_switch = 1'b0;
          end else begin
            recs[n_recs] = mk_token(tok_d, leaf_kind, leaf_s, leaf_e, '0);
            n_recs       = n_recs + 2'd1;
            tok_d        = DW'(tok_d + 1'b1);
            if ((depth_d != '0) && (top_d.kids != KIDS_MAX)) begin
              top_d.kids = KIDS_W'(top_d.kids + 1'b1);
            end
          end
        end

        if (do_switch) begin
          case (c) inside
            CH_LBRACE, CH_LBRACK: begin
              if (LW'(tok_d) >= lim) begin
                err_d = ST_NOMEM;
              end else begin
                if ((depth_d != '0) && (top_d.kids != KIDS_MAX)) begin
                  top_d.kids = KIDS_W'(top_d.kids + 1'b1);
                end
                if (depth_d < DW'(MAX_TOKENS)) begin
                  // old top goes down into the RAM
                  ram_we         = (depth_d != '0);
                  wr_frame       = top_d;
                  top_d.slot     = INDEX_W'(tok_d);
                  top_d.is_array = (c == CH_LBRACK);
                  top_d.start    = OFF_W'(pos_q);
                  top_d.kids     = '0;
                  depth_d        = DW'(depth_d + 1'b1);
                end
                tok_d = DW'(tok_d + 1'b1);
              end
            end
            CH_RBRACE, CH_RBRACK: begin
              if (depth_d == '0) begin
                err_d = ST_INVAL;
              end else if (top_d.is_array != (c == CH_RBRACK)) begin
                err_d = ST_INVAL;
              end else begin
                recs[n_recs] = mk_token(DW'(top_d.slot),
                                        top_d.is_array ? KIND_ARRAY : KIND_OBJECT,
                                        PW'(top_d.start), pos_inc, top_d.kids);
                n_recs       = n_recs + 2'd1;
                top_d        = below;
                depth_d      = DW'(depth_d - 1'b1);
              end
            end
            CH_QUOTE: begin
              mode_d = MODE_STR;
              pend_d = pos_inc;
            end
            CH_TAB, CH_CR, CH_LF, CH_SPACE, CH_COLON, CH_COMMA: begin
              // separators carry no token
            end
            CH_BSLASH: begin
              err_d = ST_INVAL;
            end
            default: begin
              if (c < CH_SPACE) begin
                err_d = ST_INVAL;
              end else begin
                mode_d = MODE_PRIM;
                pend_d = pos_q;
              end
            end
          endcase
        end
      end
    end

    // end of document: status record, then back to the reset state
    if (eot) begin
      st = err_d;
      if ((st == ST_OK) && ((mode_d == MODE_STR) || (mode_d == MODE_ESC))) begin
        st = ST_PART;
      end
      recs[n_recs]             = '0;
      recs[n_recs].record_kind = REC_STATUS;
      recs[n_recs].status      = st;
      recs[n_recs].tokens_made = LIMIT_W'(tok_d);
      n_recs                   = n_recs + 2'd1;
      mode_d  = MODE_IDLE;
      pos_d   = '0;
      pend_d  = '0;
      tok_d   = '0;
      depth_d = '0;
      err_d   = ST_OK;
    end

    if (n_recs != '0) begin
      recs[n_recs - 2'd1].last_of_run = 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Stack RAM: keeps every frame under the top. The read port always points
  // at the entry under the next top, so the pop of the following byte finds
  // it ready; a push that writes that same entry is forwarded.
  // --------------------------------------------------------------------------
  assign depth_next = accept ? depth_d : depth_q;
  assign ram_waddr  = AW'(depth_q - 1'b1);
  assign ram_raddr  = AW'(depth_next - DW'(2));

  jtok_ram #(
    .WIDTH (FW),
    .DEPTH (1 << AW)
  ) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (accept & ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wr_frame),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= LIMIT_RESET;
      mode_q   <= MODE_IDLE;
      pos_q    <= '0;
      pend_q   <= '0;
      tok_q    <= '0;
      depth_q  <= '0;
      err_q    <= ST_OK;
      byp_q    <= 1'b0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        mode_q   <= mode_d;
        pos_q    <= pos_d;
        pend_q   <= pend_d;
        tok_q    <= tok_d;
        depth_q  <= depth_d;
        err_q    <= err_d;
        wr_ptr_q <= QAW'(wr_ptr_q + n_recs);
      end
      byp_q <= accept && ram_we && (ram_waddr == ram_raddr);
      if (pop) begin
        rd_ptr_q <= QAW'(rd_ptr_q + 1'b1);
      end
      count_q <= QCW'(count_q + (accept ? QCW'(n_recs) : QCW'(0)) - QCW'(pop));
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      top_q <= top_d;
      for (int i = 0; i < RUN; i++) begin
        if (2'(i) < n_recs) begin
          fifo_q[QAW'(wr_ptr_q + QAW'(i))] <= recs[i];
        end
      end
    end
    byp_data_q <= wr_frame;
  end

  // --------------------------------------------------------------------------
  // Output
  // --------------------------------------------------------------------------
  assign rec_o.valid        = (count_q != '0);
  assign rec_o.record_kind  = fifo_q[rd_ptr_q].record_kind;
  assign rec_o.token_index  = fifo_q[rd_ptr_q].token_index;
  assign rec_o.token_kind   = fifo_q[rd_ptr_q].token_kind;
  assign rec_o.start_offset = fifo_q[rd_ptr_q].start_offset;
  assign rec_o.end_offset   = fifo_q[rd_ptr_q].end_offset;
  assign rec_o.child_count  = fifo_q[rd_ptr_q].child_count;
  assign rec_o.status       = fifo_q[rd_ptr_q].status;
  assign rec_o.tokens_made  = fifo_q[rd_ptr_q].tokens_made;
  assign rec_o.last_of_run  = fifo_q[rd_ptr_q].last_of_run;

endmodule

// File: rtl/jtok_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtok_checker
// Port-level checks of the JSON tokenizer, bound to the top level.
// ----------------------------------------------------------------------------
module jtok_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          in_eot_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input logic                          out_kind_i,
  input logic                          out_last_i,
  input logic [jtok_pkg::INDEX_W-1:0]  out_index_i,
  input logic [jtok_pkg::OFF_W-1:0]    out_start_i,
  input logic [jtok_pkg::OFF_W-1:0]    out_end_i,
  input logic [jtok_pkg::STATUS_W-1:0] out_status_i
);
  import jtok_pkg::*;

  // stalled record holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_index_i) &&
      $stable(out_start_i) && $stable(out_end_i) && $stable(out_status_i))
    else $error("stalled record changed");

  // empty record queue never blocks the byte side
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("byte side stalled with no record pending");

  // end of text always queues its status record
  a_status_follows_eot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_eot_i |=> out_valid_i)
    else $error("no record after end of text");

  // status closes its run
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_kind_i == REC_STATUS) |-> out_last_i)
    else $error("status record not marked last");

endmodule

bind json_tokenizer jtok_checker u_jtok_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (byte_i.valid),
  .in_ready_i   (byte_i.ready),
  .in_eot_i     (byte_i.end_of_text),
  .out_valid_i  (rec_o.valid),
  .out_ready_i  (rec_o.ready),
  .out_kind_i   (rec_o.record_kind),
  .out_last_i   (rec_o.last_of_run),
  .out_index_i  (rec_o.token_index),
  .out_start_i  (rec_o.start_offset),
  .out_end_i    (rec_o.end_offset),
  .out_status_i (rec_o.status)
);
